>>> hw/rtl/gdrc_pkg.sv
package gdrc_pkg;

    // Map geometry: a square grid addressed as {row, col}
    localparam int MAP_BITS  = 6;
    localparam int MAP_DIM   = 1 << MAP_BITS;
    localparam int ADDR_BITS = 2 * MAP_BITS;
    localparam int MAP_DEPTH = 1 << ADDR_BITS;
    localparam int CODE_W    = 8;

    // Screen and texture
    localparam int SCREEN_ROWS = 512;
    localparam int HALF_ROWS   = SCREEN_ROWS / 2;
    localparam int ROW_W       = 9;
    localparam int TEX_W       = 6;
    localparam int TEX_COLS    = 1 << TEX_W;

    // Datapath widths
    localparam int POS_W  = 22;           // unsigned Q6.16 position
    localparam int DIR_W  = 16;           // signed Q2.14 direction
    localparam int RD_W   = 18;           // ray direction after the camera term
    localparam int CRD_W  = MAP_BITS + 2; // signed walk coordinate, -1 .. MAP_DIM
    localparam int DLT_W  = 41;           // delta distance, up to the saturated value
    localparam int SD_W   = 49;           // running side distance
    localparam int NUM_W  = 25;           // signed wall offset numerator
    localparam int DIST_W = 24;
    localparam int HGT_W  = 16;
    localparam int DIV_W  = 38;           // dividend and quotient of the shared divider
    localparam int DVS_W  = 24;           // divisor of the shared divider
    localparam int CFG_W  = POS_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CODE_W-1:0] CODE_FLOOR = 8'h30;   // '0'
    localparam logic [CODE_W-1:0] CODE_OPEN  = 8'h4F;   // 'O'
    localparam logic [DLT_W-1:0]  DELTA_SAT  = {1'b1, {(DLT_W-1){1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [HGT_W-1:0]  HGT_MAX    = {HGT_W{1'b1}};
    localparam logic [DIV_W-1:0]  INV_NUM    = DIV_W'(1) << 30;
    localparam logic [DIV_W-1:0]  HGT_NUM    = DIV_W'(SCREEN_ROWS) << 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYER_X = 3'd0,
        REG_PLAYER_Y = 3'd1,
        REG_VIEW_X   = 3'd2,
        REG_VIEW_Y   = 3'd3,
        REG_PLANE_X  = 3'd4,
        REG_PLANE_Y  = 3'd5
    } t_reg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_CAST  = 1'b1
    } t_cmd;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_SDX_LO,
        ST_SDX_HI,
        ST_SDY_LO,
        ST_SDY_HI,
        ST_SD_SUM,
        ST_FETCH,
        ST_LOOK,
        ST_NUM,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_HGT_GO,
        ST_HGT_WAIT,
        ST_TEX_MUL,
        ST_EMIT
    } t_bstate;

    typedef struct packed {
        t_cmd                    cmd;
        logic [MAP_BITS-1:0]     col;
        logic [MAP_BITS-1:0]     row;
        logic [CODE_W-1:0]       code;
        logic signed [RD_W-1:0]  rdx;
        logic signed [RD_W-1:0]  rdy;
    } t_job;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } t_pose;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                wall_found;
        logic                hit_side;
        logic [MAP_BITS-1:0] wall_col;
        logic [MAP_BITS-1:0] wall_row;
        logic [DIST_W-1:0]   wall_distance;
        logic [HGT_W-1:0]    column_height;
        logic [ROW_W-1:0]    span_top;
        logic [ROW_W-1:0]    span_bottom;
        logic [TEX_W-1:0]    texture_col;
    } t_result;

endpackage

>>> hw/rtl/gdrc_ram.sv
module gdrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/gdrc_div.sv
module gdrc_div
    import gdrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             take;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign take  = trial >= {1'b0, r_dvs};

    // Control: count one quotient bit a cycle, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits replace the dividend bits as they shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], take};
            r_rem <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;

endmodule

>>> hw/rtl/gdrc_queue.sv
module gdrc_queue
    import gdrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

>>> hw/rtl/gdrc_front.sv
module gdrc_front
    import gdrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_cmd,
    input  logic [MAP_BITS-1:0]     i_cell_col,
    input  logic [MAP_BITS-1:0]     i_cell_row,
    input  logic [CODE_W-1:0]       i_cell_code,
    input  logic signed [DIR_W-1:0] i_camera_offset,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_hold,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_job                    o_q_job,
    output t_pose                   o_pose
);

    logic                    r_valid;
    t_cmd                    r_cmd;
    logic [MAP_BITS-1:0]     r_col;
    logic [MAP_BITS-1:0]     r_row;
    logic [CODE_W-1:0]       r_code;
    logic signed [DIR_W-1:0] r_cam;
    logic [POS_W-1:0]        r_px;
    logic [POS_W-1:0]        r_py;
    logic signed [DIR_W-1:0] r_vdx;
    logic signed [DIR_W-1:0] r_vdy;
    logic signed [DIR_W-1:0] r_cpx;
    logic signed [DIR_W-1:0] r_cpy;
    logic                    accept;
    logic                    cfg_we;
    logic signed [2*DIR_W-1:0] cam_x;
    logic signed [2*DIR_W-1:0] cam_y;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Take a beat unless the stage is stuck behind a full queue or the map is clearing
    assign o_full   = i_hold || (r_valid && i_q_full);
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;

    // Ray direction: view plus camera plane scaled by the column offset, floor shift
    assign cam_x = r_cpx * r_cam;
    assign cam_y = r_cpy * r_cam;

    always_comb begin
        o_q_job      = '0;
        o_q_job.cmd  = r_cmd;
        o_q_job.col  = r_col;
        o_q_job.row  = r_row;
        o_q_job.code = r_code;
        o_q_job.rdx  = {{(RD_W-DIR_W){r_vdx[DIR_W-1]}}, r_vdx} + cam_x[2*DIR_W-1 -: RD_W];
        o_q_job.rdy  = {{(RD_W-DIR_W){r_vdy[DIR_W-1]}}, r_vdy} + cam_y[2*DIR_W-1 -: RD_W];
    end

    assign o_pose.px = r_px;
    assign o_pose.py = r_py;

    // Stage valid and pose registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_vdx   <= 16'sd16384;
            r_vdy   <= '0;
            r_cpx   <= '0;
            r_cpy   <= 16'sd10813;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_q_push) begin
                r_valid <= 1'b0;
            end
            if (cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PLAYER_X: r_px  <= i_cfg_data[POS_W-1:0];
                    REG_PLAYER_Y: r_py  <= i_cfg_data[POS_W-1:0];
                    REG_VIEW_X:   r_vdx <= i_cfg_data[DIR_W-1:0];
                    REG_VIEW_Y:   r_vdy <= i_cfg_data[DIR_W-1:0];
                    REG_PLANE_X:  r_cpx <= i_cfg_data[DIR_W-1:0];
                    REG_PLANE_Y:  r_cpy <= i_cfg_data[DIR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_col  <= i_cell_col;
            r_row  <= i_cell_row;
            r_code <= i_cell_code;
            r_cam  <= i_camera_offset;
        end
    end

endmodule

>>> hw/rtl/gdrc_back.sv
module gdrc_back
    import gdrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pose   i_pose,
    input  logic    i_q_empty,
    input  t_job    i_q_job,
    output logic    o_q_pop,
    output logic    o_clearing,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int FAC_W  = 17;
    localparam int MUL_W  = 16;
    localparam int PROD_W = FAC_W + MUL_W;
    localparam int TP_W   = 30;

    t_bstate                 r_state;
    t_bstate                 n_state;
    logic [ADDR_BITS-1:0]    r_addr;
    logic signed [RD_W-1:0]  r_rdx;
    logic signed [RD_W-1:0]  r_rdy;
    logic [CRD_W-1:0]        r_mx;
    logic [CRD_W-1:0]        r_my;
    logic [DLT_W-1:0]        r_dx;
    logic [DLT_W-1:0]        r_dy;
    logic [SD_W-1:0]         r_sdx;
    logic [SD_W-1:0]         r_sdy;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_side;
    logic                    r_stepped;
    logic                    r_hit;
    logic                    r_oob;
    logic [NUM_W-1:0]        r_num;
    logic [DIST_W-1:0]       r_dist;
    logic [HGT_W-1:0]        r_hgt;
    logic [TP_W-1:0]         r_tprod;
    logic                    r_ov;
    t_result                 r_out;

    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_waddr;
    logic [CODE_W-1:0]       ram_wdata;
    logic [CODE_W-1:0]       ram_rdata;
    logic [ADDR_BITS-1:0]    ram_raddr;

    logic [FAC_W-1:0]        fac_x;
    logic [FAC_W-1:0]        fac_y;
    logic [FAC_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [RD_W-2:0]         abs_x;
    logic [RD_W-2:0]         abs_y;
    logic                    dx_sat;
    logic                    dy_sat;
    logic                    oob;
    logic [CODE_W-1:0]       code;
    logic                    walk_stop;
    logic [CRD_W-1:0]        num_crd;
    logic [POS_W-1:0]        num_pos;
    logic                    num_neg;
    logic [NUM_W-1:0]        num;
    logic signed [RD_W-1:0]  rd_side;
    logic [RD_W-2:0]         abs_side;
    logic [NUM_W-1:0]        abs_num;
    logic                    dist_zero;
    logic                    dist_div;
    logic signed [RD_W-1:0]  rd_other;
    logic signed [DIST_W+RD_W:0] tp_full;
    logic [15:0]             frac;
    logic [TEX_W-1:0]        tex;
    logic                    mirror;
    logic [HGT_W-2:0]        half;
    logic [HGT_W-1:0]        bot_sum;
    t_result                 res;
    logic                    emit;

    gdrc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gdrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Ray helpers
    assign abs_x  = r_rdx[RD_W-1] ? (RD_W-1)'(-r_rdx) : r_rdx[RD_W-2:0];
    assign abs_y  = r_rdy[RD_W-1] ? (RD_W-1)'(-r_rdy) : r_rdy[RD_W-2:0];
    assign dx_sat = r_rdx == '0;
    assign dy_sat = r_rdy == '0;
    assign fac_x  = r_rdx[RD_W-1] ? {1'b0, i_pose.px[15:0]}
                                  : 17'h10000 - {1'b0, i_pose.px[15:0]};
    assign fac_y  = r_rdy[RD_W-1] ? {1'b0, i_pose.py[15:0]}
                                  : 17'h10000 - {1'b0, i_pose.py[15:0]};

    // Shared multiplier for the first side distances, low half then high half
    always_comb begin
        mul_a = (r_state == ST_SDY_LO || r_state == ST_SDY_HI) ? fac_y : fac_x;
        case (r_state)
            ST_SDX_LO: mul_b = r_dx[15:0];
            ST_SDX_HI: mul_b = {1'b0, r_dx[30:16]};
            ST_SDY_LO: mul_b = r_dy[15:0];
            default:   mul_b = {1'b0, r_dy[30:16]};
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Map lookup; anything off the grid reads as code zero
    assign ram_raddr = {r_my[MAP_BITS-1:0], r_mx[MAP_BITS-1:0]};
    assign oob       = (|r_mx[CRD_W-1:MAP_BITS]) || (|r_my[CRD_W-1:MAP_BITS]);
    assign code      = r_oob ? '0 : ram_rdata;
    assign walk_stop = (code == '0) ||
                       (r_stepped && code != CODE_FLOOR && code != CODE_OPEN);

    // Offset from the player to the crossed grid line
    assign num_crd = r_side ? r_my : r_mx;
    assign num_pos = r_side ? i_pose.py : i_pose.px;
    assign num_neg = r_side ? r_rdy[RD_W-1] : r_rdx[RD_W-1];
    assign num     = {num_crd[CRD_W-1], num_crd, 16'h0000} - {3'b000, num_pos}
                     + {8'h00, num_neg, 16'h0000};
    assign rd_side  = r_side ? r_rdy : r_rdx;
    assign abs_side = r_side ? abs_y : abs_x;
    assign abs_num  = r_num[NUM_W-1] ? -r_num : r_num;
    // A zero ray component on the crossed side saturates before the sign tests
    assign dist_zero = !r_stepped ||
                       (rd_side != '0 &&
                        (r_num == '0 || (r_num[NUM_W-1] != rd_side[RD_W-1])));
    assign dist_div  = !dist_zero && rd_side != '0;

    // Texture: wall hit position along the other axis
    assign rd_other = r_side ? r_rdx : r_rdy;
    assign tp_full  = $signed({1'b0, r_dist}) * rd_other;
    assign frac     = (r_side ? i_pose.px[15:0] : i_pose.py[15:0]) + r_tprod[TP_W-1:14];
    assign mirror   = (!r_side && !r_rdx[RD_W-1] && r_rdx != '0) ||
                      (r_side && r_rdy[RD_W-1]);
    assign tex      = mirror ? TEX_W'(TEX_COLS - 1) - frac[15 -: TEX_W] : frac[15 -: TEX_W];

    // Screen span around the centre row
    assign half    = r_hgt[HGT_W-1:1];
    assign bot_sum = HGT_W'(HALF_ROWS) + {1'b0, half};

    always_comb begin
        res               = '0;
        res.wall_found    = r_hit;
        res.hit_side      = r_side;
        res.wall_col      = r_mx[MAP_BITS-1:0];
        res.wall_row      = r_my[MAP_BITS-1:0];
        res.wall_distance = r_dist;
        res.column_height = r_hgt;
        res.span_top      = ({1'b0, half} >= HGT_W'(HALF_ROWS)) ? '0
                            : ROW_W'(HGT_W'(HALF_ROWS) - {1'b0, half});
        res.span_bottom   = (bot_sum >= HGT_W'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1)
                            : bot_sum[ROW_W-1:0];
        res.texture_col   = tex;
    end

    assign emit = (r_state == ST_EMIT) && (!r_ov || i_pop);

    // Next state, map writes, queue pop and divider requests
    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {i_q_job.row, i_q_job.col};
        ram_wdata = i_q_job.code;
        div_req   = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = '0;
                if (&r_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_job.cmd == CMD_WRITE) begin
                        ram_we = 1'b1;
                    end else begin
                        n_state = ST_DX_GO;
                    end
                end
            end
            ST_DX_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = INV_NUM;
                div_req.divisor  = DVS_W'(abs_x);
                n_state          = ST_DX_WAIT;
            end
            ST_DX_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_DY_GO;
                end
            end
            ST_DY_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = INV_NUM;
                div_req.divisor  = DVS_W'(abs_y);
                n_state          = ST_DY_WAIT;
            end
            ST_DY_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_SDX_LO;
                end
            end
            ST_SDX_LO:  n_state = ST_SDX_HI;
            ST_SDX_HI:  n_state = ST_SDY_LO;
            ST_SDY_LO:  n_state = ST_SDY_HI;
            ST_SDY_HI:  n_state = ST_SD_SUM;
            ST_SD_SUM:  n_state = ST_FETCH;
            ST_FETCH:   n_state = ST_LOOK;
            ST_LOOK:    n_state = walk_stop ? ST_NUM : ST_FETCH;
            ST_NUM:     n_state = ST_DIST_GO;
            ST_DIST_GO: begin
                if (dist_div) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {abs_num[DIST_W-1:0], 14'h0000};
                    div_req.divisor  = DVS_W'(abs_side);
                    n_state          = ST_DIST_WAIT;
                end else begin
                    n_state = ST_HGT_GO;
                end
            end
            ST_DIST_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_HGT_GO;
                end
            end
            ST_HGT_GO: begin
                if (r_dist == '0) begin
                    n_state = ST_TEX_MUL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = HGT_NUM;
                    div_req.divisor  = r_dist;
                    n_state          = ST_HGT_WAIT;
                end
            end
            ST_HGT_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_TEX_MUL;
                end
            end
            ST_TEX_MUL: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_addr <= r_addr + ADDR_BITS'(1);
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Cast datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_rdx     <= i_q_job.rdx;
                r_rdy     <= i_q_job.rdy;
                r_mx      <= CRD_W'(i_pose.px[POS_W-1:16]);
                r_my      <= CRD_W'(i_pose.py[POS_W-1:16]);
                r_side    <= 1'b0;
                r_stepped <= 1'b0;
                r_hit     <= 1'b0;
            end
            ST_DX_WAIT: begin
                r_dx <= dx_sat ? DELTA_SAT : {10'h000, div_rsp.quot[30:0]};
            end
            ST_DY_WAIT: begin
                r_dy <= dy_sat ? DELTA_SAT : {10'h000, div_rsp.quot[30:0]};
            end
            ST_SDX_LO: r_prod <= mul_p;
            ST_SDX_HI: begin
                r_sdx  <= SD_W'(r_prod[PROD_W-1:16]);
                r_prod <= mul_p;
            end
            ST_SDY_LO: begin
                r_sdx  <= dx_sat ? SD_W'(fac_x) << 24 : r_sdx + SD_W'(r_prod);
                r_prod <= mul_p;
            end
            ST_SDY_HI: begin
                r_sdy  <= SD_W'(r_prod[PROD_W-1:16]);
                r_prod <= mul_p;
            end
            ST_SD_SUM: begin
                r_sdy <= dy_sat ? SD_W'(fac_y) << 24 : r_sdy + SD_W'(r_prod);
            end
            ST_FETCH: r_oob <= oob;
            ST_LOOK: begin
                // Stop on an empty code or a wall; otherwise advance one cell
                if (walk_stop) begin
                    r_hit <= code != '0;
                end else begin
                    r_stepped <= 1'b1;
                    if (r_sdx < r_sdy) begin
                        r_sdx  <= r_sdx + SD_W'(r_dx);
                        r_mx   <= r_mx + (r_rdx[RD_W-1] ? {CRD_W{1'b1}} : CRD_W'(1));
                        r_side <= 1'b0;
                    end else begin
                        r_sdy  <= r_sdy + SD_W'(r_dy);
                        r_my   <= r_my + (r_rdy[RD_W-1] ? {CRD_W{1'b1}} : CRD_W'(1));
                        r_side <= 1'b1;
                    end
                end
            end
            ST_NUM: r_num <= num;
            ST_DIST_GO: begin
                if (!dist_div) begin
                    r_dist <= dist_zero ? '0 : DIST_MAX;
                end
            end
            ST_DIST_WAIT: begin
                if (div_rsp.done) begin
                    r_dist <= (|div_rsp.quot[DIV_W-1:DIST_W]) ? DIST_MAX
                              : div_rsp.quot[DIST_W-1:0];
                end
            end
            ST_HGT_GO: begin
                if (r_dist == '0) begin
                    r_hgt <= HGT_MAX;
                end
            end
            ST_HGT_WAIT: begin
                if (div_rsp.done) begin
                    r_hgt <= (|div_rsp.quot[DIV_W-1:HGT_W]) ? HGT_MAX
                             : div_rsp.quot[HGT_W-1:0];
                end
            end
            ST_TEX_MUL: r_tprod <= tp_full[TP_W-1:0];
            default: ;
        endcase
    end

    // Result holding register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_clearing = r_state == ST_CLEAR;
    assign o_empty    = !r_ov;
    assign o_result   = r_out;

    // Map is only written by the clearing sweep or a cell write beat
    a_map_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_IDLE))
        else $error("map written outside clear or idle");

    // Each cell is examined in the cycle after its read was issued
    a_look_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOK |-> $past(r_state) == ST_FETCH)
        else $error("cell examined without a fetch");

    // A waiting result is neither lost nor altered
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_pop |=> r_ov && $stable(r_out))
        else $error("pending result disturbed");

    // Divider answers only arrive while a wait state expects them
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DX_WAIT || r_state == ST_DY_WAIT ||
                          r_state == ST_DIST_WAIT || r_state == ST_HGT_WAIT))
        else $error("unexpected divider result");

endmodule

>>> hw/rtl/grid_dda_ray_caster_core.sv
// Grid ray caster: a 64 x 64 map of 8-bit cell codes is loaded by write beats, and each
// cast beat walks one screen column's ray through it from the configured player pose.
// After reset the map is cleared one cell a cycle with full held high; configuration
// writes are taken throughout. An accepted beat passes through the intake register and
// the queue before it reaches the walker, which performs a cell write as it pops it. In
// a cast the shared restoring divider runs up to four times (two reciprocals, the distance
// and the column height), each run being a request, 38 quotient bits and an answer; the
// walk fetches each cell and then examines it, as the map memory's read is registered.
// A finished result waits in an output register; while it is not popped the walker
// holds the next result. A two-beat queue sits between intake and the walker.
module grid_dda_ray_caster_core
    import gdrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_cmd,
    input  logic [MAP_BITS-1:0]     i_cell_col,
    input  logic [MAP_BITS-1:0]     i_cell_row,
    input  logic [CODE_W-1:0]       i_cell_code,
    input  logic signed [DIR_W-1:0] i_camera_offset,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic                    o_wall_found,
    output logic                    o_hit_side,
    output logic [MAP_BITS-1:0]     o_wall_col,
    output logic [MAP_BITS-1:0]     o_wall_row,
    output logic [DIST_W-1:0]       o_wall_distance,
    output logic [HGT_W-1:0]        o_column_height,
    output logic [ROW_W-1:0]        o_span_top,
    output logic [ROW_W-1:0]        o_span_bottom,
    output logic [TEX_W-1:0]        o_texture_col
);

    logic    clearing;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_job    q_in;
    t_job    q_out;
    t_pose   pose;
    t_result result;

    gdrc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_cmd           (i_cmd),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .i_cell_code     (i_cell_code),
        .i_camera_offset (i_camera_offset),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_hold          (clearing),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (q_in),
        .o_pose          (pose)
    );

    gdrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    gdrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pose     (pose),
        .i_q_empty  (q_empty),
        .i_q_job    (q_out),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_result   (result)
    );

    // Unpack the result beat
    assign o_wall_found    = result.wall_found;
    assign o_hit_side      = result.hit_side;
    assign o_wall_col      = result.wall_col;
    assign o_wall_row      = result.wall_row;
    assign o_wall_distance = result.wall_distance;
    assign o_column_height = result.column_height;
    assign o_span_top      = result.span_top;
    assign o_span_bottom   = result.span_bottom;
    assign o_texture_col   = result.texture_col;

endmodule

>>> tb/sv/grid_dda_ray_caster_core_checker.sv
module grid_dda_ray_caster_core_checker
    import gdrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic                    i_full,
    input  logic                    i_cmd,
    input  logic [MAP_BITS-1:0]     i_cell_col,
    input  logic [MAP_BITS-1:0]     i_cell_row,
    input  logic [CODE_W-1:0]       i_cell_code,
    input  logic signed [DIR_W-1:0] i_camera_offset,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_empty,
    input  logic                    i_pop,
    input  t_result                 i_res,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    byte unsigned    grid [MAP_DEPTH];
    logic [POS_W-1:0] pos_x, pos_y;
    shortint         view_x, view_y, plane_x, plane_y;
    t_result         ray_q [$];

    function automatic longint unsigned grid_code(longint c, longint r);
        if (c < 0 || r < 0 || c >= MAP_DIM || r >= MAP_DIM)
            return 0;
        return grid[r * MAP_DIM + c];
    endfunction

    // Reciprocal magnitude of a ray component, saturated for zero
    function automatic longint unsigned recip_len(longint rd);
        longint unsigned a;
        a = rd < 0 ? -rd : rd;
        if (a == 0)
            return 64'd1 << 40;
        return (64'd1 << 30) / a;
    endfunction

    function automatic longint wall_dist(longint num, longint rd);
        longint unsigned an, ar, q;
        if (rd == 0)
            return longint'(DIST_MAX);
        if (num == 0 || ((num < 0) != (rd < 0)))
            return 0;
        an = num < 0 ? -num : num;
        ar = rd < 0 ? -rd : rd;
        q = (an << 14) / ar;
        return q > DIST_MAX ? longint'(DIST_MAX) : longint'(q);
    endfunction

    // Walk the grid from the player's cell and build the column result
    function automatic t_result cast_ray(logic signed [DIR_W-1:0] off);
        longint cam, rdx, rdy, mx, my, sx, sy, num, wdist, hpos, half, top_row, bot_row;
        longint unsigned dxl, dyl, sdx, sdy, fx, fy, tex, hgt, code;
        bit side, hit, stepped;
        t_result r;
        cam = off;
        side = 0;
        hit = 0;
        stepped = 0;
        rdx = longint'(view_x) + ((longint'(plane_x) * cam) >>> 14);
        rdy = longint'(view_y) + ((longint'(plane_y) * cam) >>> 14);
        mx = pos_x >> 16;
        my = pos_y >> 16;
        fx = pos_x & 16'hFFFF;
        fy = pos_y & 16'hFFFF;
        dxl = recip_len(rdx);
        dyl = recip_len(rdy);
        sx = rdx < 0 ? -1 : 1;
        sy = rdy < 0 ? -1 : 1;
        sdx = ((rdx < 0 ? fx : 65536 - fx) * dxl) >> 16;
        sdy = ((rdy < 0 ? fy : 65536 - fy) * dyl) >> 16;
        while (grid_code(mx, my) != 0 && !hit) begin
            if (sdx < sdy) begin
                sdx += dxl;
                mx += sx;
                side = 0;
            end else begin
                sdy += dyl;
                my += sy;
                side = 1;
            end
            stepped = 1;
            code = grid_code(mx, my);
            if (code != CODE_FLOOR && code != CODE_OPEN)
                hit = 1;
        end
        hit = hit && grid_code(mx, my) != 0;
        if (!stepped) begin
            wdist = 0;
        end else if (side == 0) begin
            num = mx * 65536 - longint'(pos_x) + (sx < 0 ? 65536 : 0);
            wdist = wall_dist(num, rdx);
        end else begin
            num = my * 65536 - longint'(pos_y) + (sy < 0 ? 65536 : 0);
            wdist = wall_dist(num, rdy);
        end
        if (wdist == 0) begin
            hgt = HGT_MAX;
        end else begin
            hgt = (longint'(SCREEN_ROWS) << 16) / wdist;
            if (hgt > HGT_MAX)
                hgt = HGT_MAX;
        end
        half = hgt / 2;
        top_row = HALF_ROWS - half;
        if (top_row < 0)
            top_row = 0;
        bot_row = HALF_ROWS + half;
        if (bot_row >= SCREEN_ROWS)
            bot_row = SCREEN_ROWS - 1;
        if (side == 0)
            hpos = longint'(pos_y) + ((wdist * rdy) >>> 14);
        else
            hpos = longint'(pos_x) + ((wdist * rdx) >>> 14);
        tex = ((hpos & 16'hFFFF) * TEX_COLS) >> 16;
        if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
            tex = TEX_COLS - 1 - tex;
        r.wall_found    = hit;
        r.hit_side      = side;
        r.wall_col      = mx[MAP_BITS-1:0];
        r.wall_row      = my[MAP_BITS-1:0];
        r.wall_distance = wdist[DIST_W-1:0];
        r.column_height = hgt[HGT_W-1:0];
        r.span_top      = top_row[ROW_W-1:0];
        r.span_bottom   = bot_row[ROW_W-1:0];
        r.texture_col   = tex[TEX_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial begin
        o_errors  = 0;
        o_checked = 0;
        o_hits    = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (grid[k])
                grid[k] = 0;
            pos_x   = 0;
            pos_y   = 0;
            view_x  = 16384;
            view_y  = 0;
            plane_x = 0;
            plane_y = 10813;
            ray_q.delete();
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PLAYER_X: pos_x = i_cfg_data;
                    REG_PLAYER_Y: pos_y = i_cfg_data;
                    REG_VIEW_X:   view_x = i_cfg_data[DIR_W-1:0];
                    REG_VIEW_Y:   view_y = i_cfg_data[DIR_W-1:0];
                    REG_PLANE_X:  plane_x = i_cfg_data[DIR_W-1:0];
                    REG_PLANE_Y:  plane_y = i_cfg_data[DIR_W-1:0];
                    default: ;
                endcase
            end
            // Apply a cell write or predict a cast
            if (i_push && !i_full) begin
                if (t_cmd'(i_cmd) == CMD_WRITE)
                    grid[{i_cell_row, i_cell_col}] = i_cell_code;
                else
                    ray_q.push_back(cast_ray(i_camera_offset));
            end
            // Compare a popped beat against the oldest prediction
            if (i_pop && !i_empty) begin
                if (ray_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: result beat with no cast outstanding", $time);
                end else begin
                    t_result e;
                    e = ray_q.pop_front();
                    check_field("wall_found", e.wall_found, i_res.wall_found);
                    check_field("hit_side", e.hit_side, i_res.hit_side);
                    check_field("wall_col", e.wall_col, i_res.wall_col);
                    check_field("wall_row", e.wall_row, i_res.wall_row);
                    check_field("wall_distance", e.wall_distance, i_res.wall_distance);
                    check_field("column_height", e.column_height, i_res.column_height);
                    check_field("span_top", e.span_top, i_res.span_top);
                    check_field("span_bottom", e.span_bottom, i_res.span_bottom);
                    check_field("texture_col", e.texture_col, i_res.texture_col);
                    o_checked++;
                    if (e.wall_found)
                        o_hits++;
                end
            end
        end
        o_pending = ray_q.size();
    end

endmodule

>>> tb/sv/grid_dda_ray_caster_core_tb.sv
module grid_dda_ray_caster_core_tb;
    import gdrc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic                    i_clk, i_rst_n;
    logic                    i_push, o_full, i_cmd;
    logic [MAP_BITS-1:0]     i_cell_col, i_cell_row;
    logic [CODE_W-1:0]       i_cell_code;
    logic signed [DIR_W-1:0] i_camera_offset;
    logic                    i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    o_empty, i_pop;
    t_result                 res;

    int errors, pending, checked, hits;
    int casts_sent, writes_sent;
    bit idling;
    int pop_hold;
    int quiet_cycles;

    grid_dda_ray_caster_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_cmd(i_cmd),
        .i_cell_col(i_cell_col), .i_cell_row(i_cell_row), .i_cell_code(i_cell_code),
        .i_camera_offset(i_camera_offset),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_wall_found(res.wall_found), .o_hit_side(res.hit_side),
        .o_wall_col(res.wall_col), .o_wall_row(res.wall_row),
        .o_wall_distance(res.wall_distance), .o_column_height(res.column_height),
        .o_span_top(res.span_top), .o_span_bottom(res.span_bottom),
        .o_texture_col(res.texture_col)
    );

    grid_dda_ray_caster_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .i_full(o_full), .i_cmd(i_cmd),
        .i_cell_col(i_cell_col), .i_cell_row(i_cell_row), .i_cell_code(i_cell_code),
        .i_camera_offset(i_camera_offset),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_empty(o_empty), .i_pop(i_pop), .i_res(res),
        .o_errors(errors), .o_pending(pending), .o_checked(checked), .o_hits(hits)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, plus a long hold-off when requested
    initial begin
        int burst;
        burst = 0;
        i_pop = 0;
        forever begin
            @(negedge i_clk);
            if (pop_hold > 0) begin
                i_pop <= 0;
                pop_hold--;
            end else if (burst > 0) begin
                i_pop <= 0;
                burst--;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 15) - 1;
                i_pop <= 0;
            end else begin
                i_pop <= 1;
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_beat(t_cmd cmd, int col, int row, int code, int off);
        if (idling && $urandom_range(0, 5) == 0) begin
            i_push <= 0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_push          <= 1;
        i_cmd           <= cmd;
        i_cell_col      <= col[MAP_BITS-1:0];
        i_cell_row      <= row[MAP_BITS-1:0];
        i_cell_code     <= code[CODE_W-1:0];
        i_camera_offset <= off[DIR_W-1:0];
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
        if (cmd == CMD_CAST)
            casts_sent++;
        else
            writes_sent++;
    endtask

    task automatic write_cell(int col, int row, int code);
        send_beat(CMD_WRITE, col, row, code, $urandom_range(0, 65535));
    endtask

    task automatic cast(int off);
        send_beat(CMD_CAST, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 255), off);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Drain all casts, then let trailing cell writes retire
    task automatic settle();
        i_push <= 0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (500) @(negedge i_clk);
    endtask

    function automatic int pick_code();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5)
            return int'(CODE_FLOOR);
        if (p < 7)
            return int'(CODE_OPEN);
        if (p < 9)
            return $urandom_range(1, 255);
        return 0;
    endfunction

    function automatic int pick_dir();
        int p;
        p = $urandom_range(0, 5);
        if (p == 0)
            return -32768;
        if (p == 1)
            return 32767;
        return $urandom_range(0, 65535) - 32768;
    endfunction

    initial begin
        int pcx, pcy, n_wr, n_cast, c, r;
        logic [CFG_W-1:0] px, py;
        i_rst_n = 0;
        i_push = 0;
        i_cmd = CMD_WRITE;
        i_cell_col = 0;
        i_cell_row = 0;
        i_cell_code = 0;
        i_camera_offset = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_PLAYER_X;
        i_cfg_data = 0;
        idling = 1;
        pop_hold = 0;
        quiet_cycles = 0;
        casts_sent = 0;
        writes_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: casts on the cleared map stop at once on the zero start cell
        cast(0);
        cast(-16384);
        cast(16384);
        settle();
        // Small corridor from cell (10,10); straight cast has a zero y component
        write_reg(REG_PLAYER_X, (22'd10 << 16) | 22'h8000);
        write_reg(REG_PLAYER_Y, (22'd10 << 16) | 22'h8000);
        write_cell(10, 10, int'(CODE_FLOOR));
        write_cell(11, 10, int'(CODE_OPEN));
        write_cell(12, 10, "#");
        write_cell(10, 11, int'(CODE_FLOOR));
        write_cell(10, 9, 255);
        write_cell(9, 10, int'(CODE_FLOOR));
        write_cell(63, 63, 255);
        write_cell(0, 0, 0);
        cast(0);
        cast(16384);
        cast(-16384);
        cast(8192);
        cast(-1);
        settle();
        // Facing back along minus x, walk leaves the written cells into zero code
        write_reg(REG_VIEW_X, 22'h3C000);
        write_reg(REG_PLANE_Y, 22'h3D5C3);
        cast(0);
        cast(16384);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            idling = (ph != 7);
            // Pose: corners in two phases, map edges sometimes, random otherwise
            if (ph == 1) begin
                px = 22'h3FFFFF;
                py = 22'h3FFFFF;
            end else if (ph == 2) begin
                px = 0;
                py = 0;
            end else begin
                px = CFG_W'($urandom_range(0, 22'h3FFFFF));
                py = CFG_W'($urandom_range(0, 22'h3FFFFF));
                if ($urandom_range(0, 1))
                    px[21:16] = $urandom_range(0, 1) ? 6'd0
                                : 6'(62 + $urandom_range(0, 1));
            end
            pcx = int'(px[21:16]);
            pcy = int'(py[21:16]);
            write_reg(REG_PLAYER_X, px);
            write_reg(REG_PLAYER_Y, py);
            write_reg(REG_VIEW_X, CFG_W'(pick_dir()));
            write_reg(REG_VIEW_Y, CFG_W'(pick_dir()));
            write_reg(REG_PLANE_X, CFG_W'(pick_dir()));
            write_reg(REG_PLANE_Y, CFG_W'(pick_dir()));

            // Mostly a room of floor cells around the player, with some noise writes
            write_cell(pcx, pcy, $urandom_range(0, 1) ? int'(CODE_FLOOR) : int'(CODE_OPEN));
            n_wr = 0;
            while (n_wr < 40) begin
                if ($urandom_range(0, 9) == 0) begin
                    write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 255));
                end else begin
                    c = pcx + $urandom_range(0, 10) - 5;
                    r = pcy + $urandom_range(0, 10) - 5;
                    if (c >= 0 && c < MAP_DIM && r >= 0 && r < MAP_DIM)
                        write_cell(c, r, pick_code());
                end
                n_wr++;
            end

            // Long receiver hold-off so the block fills and stalls intake
            if (ph == 3)
                pop_hold = 2000;

            for (n_cast = 0; n_cast < 35; n_cast++) begin
                if ($urandom_range(0, 9) == 0)
                    cast($urandom_range(0, 1) ? 16384 : -16384);
                else
                    cast($urandom_range(0, 32768) - 16384);
                if ($urandom_range(0, 7) == 0)
                    write_cell(pcx + $urandom_range(0, 2) - 1 & 63,
                               pcy + $urandom_range(0, 2) - 1 & 63, pick_code());
            end
            settle();
        end

        $display("Sent %0d cell writes and %0d casts; %0d results checked, %0d wall hits.",
                 writes_sent, casts_sent, checked, hits);
        $display("Poses covered map corners and edges, direction extremes and stalls.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
